### design/fdl_pkg.sv
// ----------------------------------------------------------------------------
// Fractional delay line package
// Shared constants, payload types, control structs and a helper function of
// the Lagrange interpolated fractional delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package fdl_pkg;

    localparam int LINE_LENGTH     = 4096;
    localparam int ADDR_W          = $clog2(LINE_LENGTH);
    localparam int INTERP_ORDER    = 3;
    localparam int HALF_ORDER      = INTERP_ORDER / 2;
    localparam int NTAPS           = INTERP_ORDER + 1;
    localparam int TAP_W           = $clog2(NTAPS);
    localparam int SAMPLE_BITS     = 24;
    localparam int DELAY_FRAC_BITS = 16;
    localparam int DELAY_W         = 28;
    localparam int WQ              = 16;

    localparam int D_W       = WQ + 3;
    localparam int NUM_MAG_W = 22;
    localparam int W_W       = NUM_MAG_W + 1;
    localparam int DEN_W     = 13;
    localparam int DIV_SHIFT = 32;
    localparam int RECIP_W   = 33;
    localparam int PROD_W    = W_W + SAMPLE_BITS;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int MAG_W     = ACC_W + 1 - WQ;

    localparam logic [DELAY_W-1:0] MIN_DELAY_RESET = DELAY_W'(131072);
    localparam logic [DELAY_W-1:0] UPPER_DELAY =
        DELAY_W'(64'(LINE_LENGTH - INTERP_ORDER) << DELAY_FRAC_BITS);
    localparam logic [MAG_W-1:0] SAT_HI =
        MAG_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] SAT_LO_MAG = MAG_W'(64'd1 << (SAMPLE_BITS - 1));

    // Step schedule of a read, counted in the run state.
    localparam int SCALE_AT  = INTERP_ORDER;
    localparam int FINISH_AT = INTERP_ORDER + 1;
    localparam int MAC_FIRST = INTERP_ORDER + 2;
    localparam int MAC_LAST  = MAC_FIRST + NTAPS - 1;
    localparam int ACC_FIRST = MAC_FIRST + 1;
    localparam int ACC_LAST  = MAC_LAST + 1;
    localparam int ROUND_AT  = ACC_LAST + 1;
    localparam int SAT_AT    = ROUND_AT + 1;
    localparam int CNT_W     = $clog2(SAT_AT + 1);

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [1:0]                    opcode;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [DELAY_W-1:0]            delay_amount;
    } fdl_cmd_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          delay_clamped;
    } fdl_res_t;

    typedef struct packed {
        logic             init;
        logic             mul;
        logic             scale;
        logic             finish;
        logic [TAP_W-1:0] step;
    } fdl_wctl_t;

    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
        logic round;
        logic sat;
    } fdl_mctl_t;

    function automatic int unsigned fdl_den_mag(input int unsigned k);
        int unsigned p;
        int          diff;
        p = 1;
        for (int j = 0; j <= INTERP_ORDER; j++)
        begin
            if (j != int'(k))
            begin
                diff = int'(k) - j;
                p = p * int'(diff < 0 ? -diff : diff);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### design/fdl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/fdl_weight.sv
// ----------------------------------------------------------------------------
// Lagrange weight lane
// Builds the weight of one tap: a chain of rounded Q.16 products over the
// other taps, then a rounded division by the integer denominator done as a
// multiplication by its reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_weight
    import fdl_pkg::*;
(
    input  wire logic                  clk,
    input  wire fdl_wctl_t             ctrl,
    input  wire logic [D_W-1:0]        d,
    input  wire logic [TAP_W-1:0]      lane_idx,
    input  wire logic [DEN_W-1:0]      den_mag,
    input  wire logic [RECIP_W-1:0]    recip,
    input  wire logic                  den_neg,
    output logic signed [W_W-1:0]      weight
);

    logic [NUM_MAG_W-1:0]           num_mag_reg;
    logic [NUM_MAG_W-1:0]           num_mag_next;
    logic                           num_neg_reg;
    logic                           num_neg_next;
    logic [NUM_MAG_W+RECIP_W:0]     sprod_reg;
    logic [NUM_MAG_W+RECIP_W:0]     sprod_next;
    logic signed [W_W-1:0]          weight_reg;
    logic signed [W_W-1:0]          weight_next;

    logic [TAP_W-1:0]               j;
    logic signed [D_W:0]            factor;
    logic                           fneg;
    logic [D_W-1:0]                 fmag;
    logic [NUM_MAG_W+D_W-1:0]       mprod;
    logic [NUM_MAG_W+D_W-1:0]       mround;
    logic [NUM_MAG_W:0]             xval;
    logic [NUM_MAG_W-1:0]           quot;

    always_comb
    begin
        j      = (ctrl.step < lane_idx) ? ctrl.step : ctrl.step + TAP_W'(1);
        factor = $signed({1'b0, d}) - $signed({1'b0, D_W'(D_W'(j) << WQ)});
        fneg   = factor[D_W];
        fmag   = fneg ? D_W'(-factor) : D_W'(factor);
        mprod  = num_mag_reg * fmag;
        mround = mprod + (NUM_MAG_W + D_W)'(1 << (WQ - 1));
        xval   = {1'b0, num_mag_reg} + (NUM_MAG_W + 1)'(den_mag >> 1);
        quot   = sprod_reg[DIV_SHIFT +: NUM_MAG_W];

        num_mag_next = num_mag_reg;
        num_neg_next = num_neg_reg;
        sprod_next   = sprod_reg;
        weight_next  = weight_reg;
        if (ctrl.init)
        begin
            num_mag_next = NUM_MAG_W'(1 << WQ);
            num_neg_next = 1'b0;
        end
        if (ctrl.mul)
        begin
            num_mag_next = mround[WQ +: NUM_MAG_W];
            num_neg_next = num_neg_reg ^ fneg;
        end
        if (ctrl.scale)
        begin
            sprod_next = xval * recip;
        end
        if (ctrl.finish)
        begin
            weight_next = (num_neg_reg ^ den_neg) ? -$signed({1'b0, quot})
                                                  : $signed({1'b0, quot});
        end
    end

    always_ff @(posedge clk)
    begin
        num_mag_reg <= num_mag_next;
        num_neg_reg <= num_neg_next;
        sprod_reg   <= sprod_next;
        weight_reg  <= weight_next;
    end

    assign weight = weight_reg;

endmodule

`default_nettype wire

### design/fdl_mac.sv
// ----------------------------------------------------------------------------
// Tap accumulator
// Multiplies one weight by one tap per cycle, accumulates the exact sum, then
// rounds it back to the sample scale and saturates it.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_mac
    import fdl_pkg::*;
(
    input  wire logic                          clk,
    input  wire fdl_mctl_t                     ctrl,
    input  wire logic signed [W_W-1:0]         weight,
    input  wire logic signed [SAMPLE_BITS-1:0] tap,
    output logic signed [SAMPLE_BITS-1:0]      sample_out
);

    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic [MAG_W-1:0]              mag_reg;
    logic [MAG_W-1:0]              mag_next;
    logic signed [SAMPLE_BITS-1:0] res_reg;
    logic signed [SAMPLE_BITS-1:0] res_next;

    logic [ACC_W-1:0]              absv;
    logic [ACC_W:0]                rsum;

    always_comb
    begin
        absv = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        rsum = {1'b0, absv} + (ACC_W + 1)'(1 << (WQ - 1));

        prod_next = prod_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        res_next  = res_reg;
        if (ctrl.mul)
        begin
            prod_next = weight * tap;
        end
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        if (ctrl.round)
        begin
            neg_next = acc_reg[ACC_W-1];
            mag_next = rsum[ACC_W:WQ];
        end
        if (ctrl.sat)
        begin
            if (!neg_reg)
            begin
                res_next = (mag_reg > SAT_HI) ? SAT_HI[SAMPLE_BITS-1:0]
                                              : mag_reg[SAMPLE_BITS-1:0];
            end
            else
            begin
                res_next = (mag_reg > SAT_LO_MAG) ? SAT_LO_MAG[SAMPLE_BITS-1:0]
                                                  : -mag_reg[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        mag_reg  <= mag_next;
        res_reg  <= res_next;
    end

    assign sample_out = res_reg;

endmodule

`default_nettype wire

### design/fractional_delay_line_lagrange.sv
// ----------------------------------------------------------------------------
// Fractional delay line with Lagrange interpolation
// Circular line of samples in one RAM; reads return a third order Lagrange
// interpolation at a clamped fractional delay.
//
//   Channel   Signals                      Transaction
//   command   start, busy, cmd             start high while busy low
//   result    result_valid, result         one cycle strobe, cannot stall
//   config    cfg_valid, cfg_ready, cfg_data  valid and ready high
//
// A write or an unused opcode is taken straight from idle and busy stays low.
// A read keeps busy high through a clamp state, then four RAM tap reads
// on the single read port overlapped with three multiply steps and the
// divide of the weight lanes, four multiply-accumulate steps, round and
// saturate. The result strobe comes in the cycle busy falls.
// A clear, and reset, sweep zeros through all 4096 RAM entries, one per
// cycle, with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module fractional_delay_line_lagrange
    import fdl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire fdl_cmd_t           cmd,
    output logic                    result_valid,
    output fdl_res_t                result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [DELAY_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CLEAR = 4'b0010,
        ST_CLAMP = 4'b0100,
        ST_RUN   = 4'b1000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [ADDR_W-1:0]             clr_addr_reg;
    logic [ADDR_W-1:0]             clr_addr_next;
    logic [ADDR_W-1:0]             wp_reg;
    logic [ADDR_W-1:0]             wp_next;
    logic [DELAY_W-1:0]            min_delay_reg;
    logic [DELAY_W-1:0]            min_delay_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [DELAY_W-1:0]            req_reg;
    logic [DELAY_W-1:0]            req_next;
    logic [D_W-1:0]                d_reg;
    logic [D_W-1:0]                d_next;
    logic [ADDR_W-1:0]             base_reg;
    logic [ADDR_W-1:0]             base_next;
    logic                          clamped_reg;
    logic                          clamped_next;
    logic signed [SAMPLE_BITS-1:0] tap_reg [NTAPS];

    logic                          accept;
    logic [DELAY_W-1:0]            c_lo;
    logic [DELAY_W-1:0]            c_val;
    logic [ADDR_W-1:0]             int_delay;
    logic [WQ-1:0]                 f16;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic [TAP_W-1:0]              mac_idx;
    fdl_wctl_t                     wctl;
    fdl_mctl_t                     mctl;
    logic signed [W_W-1:0]         w_arr [NTAPS];
    logic signed [SAMPLE_BITS-1:0] mac_out;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        c_lo      = (req_reg < min_delay_reg) ? min_delay_reg : req_reg;
        c_val     = (c_lo > UPPER_DELAY) ? UPPER_DELAY : c_lo;
        int_delay = ADDR_W'(c_val >> DELAY_FRAC_BITS);
        f16       = (DELAY_FRAC_BITS >= WQ)
                    ? WQ'(c_val[DELAY_FRAC_BITS-1:0] >> (DELAY_FRAC_BITS - WQ))
                    : WQ'(c_val[DELAY_FRAC_BITS-1:0] << (WQ - DELAY_FRAC_BITS));
        mac_idx   = TAP_W'(cnt_reg - CNT_W'(MAC_FIRST));
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        clr_addr_next  = clr_addr_reg;
        wp_next        = wp_reg;
        min_delay_next = min_delay_reg;
        valid_next     = 1'b0;
        req_next       = req_reg;
        d_next         = d_reg;
        base_next      = base_reg;
        clamped_next   = clamped_reg;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = cmd.sample_in;

        if (cfg_valid && cfg_ready)
        begin
            min_delay_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        OP_READ:
                        begin
                            req_next   = cmd.delay_amount;
                            state_next = ST_CLAMP;
                        end
                        OP_WRITE:
                        begin
                            ram_we  = 1'b1;
                            wp_next = wp_reg + ADDR_W'(1);
                        end
                        OP_CLEAR:
                        begin
                            wp_next       = '0;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(LINE_LENGTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLAMP:
            begin
                d_next       = D_W'(f16) + D_W'(HALF_ORDER << WQ);
                base_next    = wp_reg - int_delay + ADDR_W'(HALF_ORDER);
                clamped_next = (c_val != req_reg);
                cnt_next     = '0;
                state_next   = ST_RUN;
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SAT_AT))
                begin
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_raddr   = base_reg - ADDR_W'(cnt_reg);
        wctl.init   = (state_reg == ST_CLAMP);
        wctl.mul    = (state_reg == ST_RUN) && (cnt_reg < CNT_W'(INTERP_ORDER));
        wctl.scale  = (state_reg == ST_RUN) && (cnt_reg == CNT_W'(SCALE_AT));
        wctl.finish = (state_reg == ST_RUN) && (cnt_reg == CNT_W'(FINISH_AT));
        wctl.step   = TAP_W'(cnt_reg);
        mctl.clear  = (state_reg == ST_CLAMP);
        mctl.mul    = (state_reg == ST_RUN) && (cnt_reg >= CNT_W'(MAC_FIRST))
                      && (cnt_reg <= CNT_W'(MAC_LAST));
        mctl.acc    = (state_reg == ST_RUN) && (cnt_reg >= CNT_W'(ACC_FIRST))
                      && (cnt_reg <= CNT_W'(ACC_LAST));
        mctl.round  = (state_reg == ST_RUN) && (cnt_reg == CNT_W'(ROUND_AT));
        mctl.sat    = (state_reg == ST_RUN) && (cnt_reg == CNT_W'(SAT_AT));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_addr_reg  <= '0;
            wp_reg        <= '0;
            min_delay_reg <= MIN_DELAY_RESET;
            valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            clr_addr_reg  <= clr_addr_next;
            wp_reg        <= wp_next;
            min_delay_reg <= min_delay_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        d_reg       <= d_next;
        base_reg    <= base_next;
        clamped_reg <= clamped_next;
        if ((state_reg == ST_RUN) && (cnt_reg >= CNT_W'(1))
            && (cnt_reg <= CNT_W'(NTAPS)))
        begin
            tap_reg[TAP_W'(cnt_reg - CNT_W'(1))] <= $signed(ram_rdata);
        end
    end

    fdl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_LENGTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    for (genvar k = 0; k < NTAPS; k++)
    begin : g_lane
        localparam int unsigned DEN = fdl_den_mag(k);
        localparam longint unsigned RECIP =
            ((64'd1 << DIV_SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
        localparam bit DEN_NEG = ((INTERP_ORDER - k) % 2) == 1;

        fdl_weight u_weight (
            .clk      (clk),
            .ctrl     (wctl),
            .d        (d_reg),
            .lane_idx (TAP_W'(k)),
            .den_mag  (DEN_W'(DEN)),
            .recip    (RECIP_W'(RECIP)),
            .den_neg  (DEN_NEG),
            .weight   (w_arr[k])
        );
    end

    fdl_mac u_mac (
        .clk        (clk),
        .ctrl       (mctl),
        .weight     (w_arr[mac_idx]),
        .tap        (tap_reg[mac_idx]),
        .sample_out (mac_out)
    );

    assign result_valid         = valid_reg;
    assign result.sample_out    = mac_out;
    assign result.delay_clamped = clamped_reg;

endmodule

`default_nettype wire

### design/fdl_checker.sv
// ----------------------------------------------------------------------------
// Fractional delay line checker
// Port level assertions on command and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fdl_checker
    import fdl_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire fdl_cmd_t cmd,
    input wire logic     result_valid
);

    // A result strobe lasts one cycle, since each read first passes through the clamp and run states.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // The block is free again when it shows a result.
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("busy while a result is shown");

    // A write transaction finishes at once and gives no result.
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.opcode == OP_WRITE)) |=> (!busy && !result_valid))
        else $error("write transaction did not complete in one cycle");

    // A read or clear transaction keeps the block busy in the next cycle.
    a_long_ops_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd.opcode == OP_READ) || (cmd.opcode == OP_CLEAR)))
        |=> busy)
        else $error("read or clear transaction did not raise busy");

endmodule

bind fractional_delay_line_lagrange fdl_checker u_fdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid)
);

`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the Lagrange interpolated fractional delay line
// Drives writes, reads, clears and unused opcodes through the start and busy
// command channel, changes the minimum delay register between phases, and
// compares every interpolated result against a bit accurate scoreboard.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fdl_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int FILL_ITEMS = 200;
    localparam int PHASE_ITEMS = 125;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    class delay_line_scoreboard;
        logic signed [SAMPLE_BITS-1:0] line_mem [LINE_LENGTH];
        logic [ADDR_W-1:0]             wr_ptr;
        logic [DELAY_W-1:0]            min_delay;
        fdl_res_t                      pending_samples [$];
        int                            errors;

        function new();
            clear_line();
            min_delay = MIN_DELAY_RESET;
            errors = 0;
        endfunction

        function void clear_line();
            foreach (line_mem[i])
            begin
                line_mem[i] = '0;
            end
            wr_ptr = '0;
        endfunction

        function longint magnitude(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function longint round_mul(longint a, longint b);
            longint m;
            m = (magnitude(a) * magnitude(b) + (longint'(1) << (WQ - 1))) >> WQ;
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function longint round_div(longint a, longint b);
            longint m;
            m = (magnitude(a) + magnitude(b) / 2) / magnitude(b);
            return ((a < 0) != (b < 0)) ? -m : m;
        endfunction

        function fdl_res_t interpolate(logic [DELAY_W-1:0] req);
            fdl_res_t           res;
            logic [DELAY_W-1:0] eff;
            logic [ADDR_W-1:0]  idx;
            longint             d;
            longint             first;
            longint             num;
            longint             den;
            longint             acc;
            longint             m;
            longint             r;
            longint             hi;
            eff = req;
            if (eff < min_delay)
                eff = min_delay;
            if (eff > UPPER_DELAY)
                eff = UPPER_DELAY;
            d = longint'(eff[DELAY_FRAC_BITS-1:0]) + (longint'(HALF_ORDER) << WQ);
            first = longint'(eff >> DELAY_FRAC_BITS) - HALF_ORDER;
            acc = 0;
            for (int k = 0; k <= INTERP_ORDER; k++)
            begin
                num = longint'(1) << WQ;
                den = 1;
                for (int j = 0; j <= INTERP_ORDER; j++)
                begin
                    if (j != k)
                    begin
                        num = round_mul(num, d - (longint'(j) << WQ));
                        den = den * (k - j);
                    end
                end
                idx = ADDR_W'(longint'(wr_ptr) - first - k);
                acc += round_div(num, den) * longint'(line_mem[idx]);
            end
            m = (magnitude(acc) + (longint'(1) << (WQ - 1))) >> WQ;
            r = (acc < 0) ? -m : m;
            hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
            if (r > hi)
                r = hi;
            if (r < -hi - 1)
                r = -hi - 1;
            res.sample_out = SAMPLE_BITS'(r);
            res.delay_clamped = (eff != req);
            return res;
        endfunction

        function void note_command(fdl_cmd_t c);
            if (c.opcode == OP_WRITE)
            begin
                line_mem[wr_ptr] = c.sample_in;
                wr_ptr++;
            end
            else if (c.opcode == OP_CLEAR)
                clear_line();
            else if (c.opcode == OP_READ)
                pending_samples.push_back(interpolate(c.delay_amount));
        endfunction

        function void check_result(fdl_res_t got);
            fdl_res_t want;
            if (pending_samples.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, %s%0d clamped=%0b",
                         $time, "actual sample_out=", got.sample_out, got.delay_clamped);
                return;
            end
            want = pending_samples.pop_front();
            if (got.sample_out !== want.sample_out)
            begin
                errors++;
                $display("%0t: sample_out mismatch, expected %0d actual %0d",
                         $time, want.sample_out, got.sample_out);
            end
            if (got.delay_clamped !== want.delay_clamped)
            begin
                errors++;
                $display("%0t: delay_clamped mismatch, expected %0b actual %0b",
                         $time, want.delay_clamped, got.delay_clamped);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    fdl_cmd_t           cmd = '0;
    logic               cfg_valid = 1'b0;
    logic [DELAY_W-1:0] cfg_data = '0;
    logic               busy;
    logic               result_valid;
    logic               cfg_ready;
    fdl_res_t           result;
    int                 idle_cycles = 0;

    delay_line_scoreboard sb = new();

    fractional_delay_line_lagrange u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic issue(input fdl_cmd_t c);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(c);
    endtask

    task automatic send(input logic [1:0] op, input logic signed [SAMPLE_BITS-1:0] sample,
                        input logic [DELAY_W-1:0] delay);
        fdl_cmd_t c;
        c.opcode = op;
        c.sample_in = sample;
        c.delay_amount = delay;
        issue(c);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (busy || sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_min_delay(input logic [DELAY_W-1:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.min_delay = value;
    endtask

    function automatic fdl_cmd_t random_cmd(input bit writes_only);
        fdl_cmd_t c;
        int       pick;
        c.opcode = OP_READ;
        c.sample_in = SAMPLE_BITS'($urandom);
        c.delay_amount = DELAY_W'($urandom);
        pick = writes_only ? 0 : $urandom_range(0, 999);
        if (pick < 500)
        begin
            c.opcode = OP_WRITE;
            if ($urandom_range(0, 9) == 0)
                c.sample_in = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
        end
        else if (pick < 504)
            c.opcode = OP_CLEAR;
        else if (pick < 540)
            c.opcode = OP_UNUSED;
        else
        begin
            case ($urandom_range(0, 6))
                0, 1, 2, 3:
                    c.delay_amount = (DELAY_W'($urandom_range(0, 40)) << DELAY_FRAC_BITS)
                                     | DELAY_W'($urandom_range(0, 65535));
                4:
                    c.delay_amount = DELAY_W'($urandom);
                5:
                    c.delay_amount = UPPER_DELAY + DELAY_W'($urandom_range(0, 4 << 16))
                                     - DELAY_W'(2 << 16);
                default:
                    c.delay_amount = sb.min_delay + DELAY_W'($urandom_range(0, 2))
                                     - DELAY_W'(1);
            endcase
        end
        return c;
    endfunction

    task automatic run_traffic(input int count, input bit writes_only);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && left > 0)
            begin
                issue(random_cmd(writes_only));
                burst--;
                left--;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
                pause(gap);
        end
    endtask

    initial
    begin
        logic [DELAY_W-1:0] min_delay_plan [6];
        min_delay_plan[0] = '0;
        min_delay_plan[1] = UPPER_DELAY;
        min_delay_plan[2] = {DELAY_W{1'b1}};
        min_delay_plan[3] = DELAY_W'($urandom_range(0, 64 << 16));
        min_delay_plan[4] = DELAY_W'($urandom);
        min_delay_plan[5] = DELAY_W'(1 << DELAY_FRAC_BITS);

        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_READ, '0, '0);
        send(OP_WRITE, SAMPLE_MIN, '0);
        send(OP_WRITE, SAMPLE_MAX, '0);
        send(OP_WRITE, SAMPLE_MAX, '0);
        send(OP_WRITE, SAMPLE_MIN, '0);
        send(OP_READ, '0, 28'h0028000);
        send(OP_WRITE, SAMPLE_MAX, '0);
        send(OP_WRITE, SAMPLE_MIN, '0);
        send(OP_WRITE, SAMPLE_MIN, '0);
        send(OP_WRITE, SAMPLE_MAX, '0);
        send(OP_READ, '0, 28'h0028000);
        send(OP_WRITE, '0, '0);
        send(OP_WRITE, -24'sd1, '0);
        send(OP_WRITE, 24'sd1, '0);
        send(OP_READ, '0, 28'h0020000);
        send(OP_READ, '0, 28'h002FFFF);
        send(OP_READ, SAMPLE_MAX, {DELAY_W{1'b1}});
        send(OP_READ, '0, UPPER_DELAY);
        send(OP_UNUSED, SAMPLE_MIN, {DELAY_W{1'b1}});
        write_min_delay('0);
        send(OP_READ, '0, '0);
        send(OP_READ, '0, 28'h0008000);
        write_min_delay({DELAY_W{1'b1}});
        send(OP_READ, '0, 28'h0030000);
        send(OP_CLEAR, '0, '0);
        send(OP_READ, '0, 28'h0028000);

        write_min_delay(MIN_DELAY_RESET);
        run_traffic(FILL_ITEMS, 1'b1);
        run_traffic(PHASE_ITEMS, 1'b0);
        foreach (min_delay_plan[p])
        begin
            write_min_delay(min_delay_plan[p]);
            run_traffic(PHASE_ITEMS, 1'b0);
        end

        start <= 1'b0;
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
